@@ rtl/core/lsc_pkg.sv @@
// Shared constants, types and helpers for the lidar scan to cartesian block.
`timescale 1ns / 1ps
package lsc_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int TRIG_FRAC  = 16;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int MAG_W      = TRIG_FRAC + 1;
	localparam int ANG_W      = 22;
	localparam int HEX_W      = 32;
	localparam int PNUM_W     = 10;
	localparam int COORD_W    = 17;
	localparam int TBA_W      = 8;
	localparam int Q_W        = 30;
	localparam int T_W        = 31;
	localparam int PX_W       = HEX_W + MAG_W;

	localparam logic [ANG_W-1:0] TURN    = 22'd3600000;
	localparam logic [ANG_W-1:0] QUARTER = 22'd900000;
	localparam logic [ANG_W-1:0] EIGHTH  = 22'd450000;
	localparam logic [ANG_W-1:0] HALF    = 22'd1800000;
	localparam logic [ANG_W-1:0] THREEQ  = 22'd2700000;
	localparam logic [32:0]      RAD_Q52 = 33'd7860264169;
	localparam logic [T_W-1:0]   Q30_ONE = 31'h4000_0000;
	localparam logic [15:0]      COORD_MAX = 16'hFFFF;

	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam int SIN_N = 5;
	localparam int COS_N = 6;

	localparam logic [7:0] SIN_DIV [SIN_N] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [7:0] COS_DIV [COS_N] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

	localparam logic [31:0] SIN_RCP [SIN_N] = '{
		32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
		32'(64'd4294967296 / 64'd42), 32'(64'd4294967296 / 64'd20),
		32'(64'd4294967296 / 64'd6)};
	localparam logic [31:0] COS_RCP [COS_N] = '{
		32'(64'd4294967296 / 64'd132), 32'(64'd4294967296 / 64'd90),
		32'(64'd4294967296 / 64'd56), 32'(64'd4294967296 / 64'd30),
		32'(64'd4294967296 / 64'd12), 32'(64'd4294967296 / 64'd2)};

	typedef enum logic [1:0] {
		CFG_TBA   = 2'd0,
		CFG_FIRST = 2'd1,
		CFG_STEP  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD,
		PH_STEP,
		PH_COUNT,
		PH_GAP,
		PH_DIST,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [HEX_W-1:0]  r;
		logic [ANG_W-1:0]  angle;
		logic [PNUM_W-1:0] pnum;
		logic              last;
	} launch_t;

	// round half up, saturate, then apply sign
	function automatic logic [COORD_W-1:0] project(input logic [PX_W-1:0] px, input logic neg);
		logic [PX_W:0]             sum;
		logic [PX_W-TRIG_FRAC:0]   m;
		logic [15:0]               sat;
		logic [COORD_W-1:0]        mag;
		sum = {1'b0, px} + ((PX_W+1)'(1) << (TRIG_FRAC - 1));
		m   = sum[PX_W:TRIG_FRAC];
		sat = (m > (PX_W-TRIG_FRAC+1)'(COORD_MAX)) ? COORD_MAX : m[15:0];
		mag = {1'b0, sat};
		return neg ? (~mag + 1'b1) : mag;
	endfunction

endpackage

@@ rtl/core/lsc_horner_cell.sv @@
// One Horner step: t_out = 1 - ((x2 * t_in) >> 30) / divisor, three stages.
`timescale 1ns / 1ps
module lsc_horner_cell
	import lsc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_in,
	input  logic [Q_W-1:0] x2,
	input  logic [T_W-1:0] t_in,
	input  logic [7:0]     divisor,
	input  logic [31:0]    rcp,
	output logic           v_out,
	output logic [T_W-1:0] t_out
);

	logic [Q_W+T_W-1:0] prod1;
	logic [Q_W+31:0]    prod2;
	logic [Q_W+7:0]     qk;
	logic [Q_W-1:0]     rem;
	logic [Q_W-1:0]     quo;
	logic [Q_W-1:0]     p_s1, p_s2, q0_s2;
	logic [T_W-1:0]     t_s3;
	logic               v_s1, v_s2, v_s3;

	assign prod1 = x2 * t_in;
	assign prod2 = p_s1 * rcp;
	assign qk    = q0_s2 * divisor;
	assign rem   = p_s2 - qk[Q_W-1:0];
	// reciprocal estimate is low by at most one
	assign quo   = (rem >= Q_W'(divisor)) ? q0_s2 + 1'b1 : q0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_in) p_s1 <= prod1[2*Q_W-1:Q_W];
		if (v_s1) begin
			p_s2  <= p_s1;
			q0_s2 <= prod2[Q_W+31:32];
		end
		if (v_s2) t_s3 <= Q30_ONE - {1'b0, quo};
	end

	assign v_out = v_s3;
	assign t_out = t_s3;

endmodule

@@ rtl/core/lsc_trig.sv @@
// Sine and cosine of an angle: octant fold, radians, two chains of Horner cells.
`timescale 1ns / 1ps
module lsc_trig
	import lsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_in,
	input  logic [ANG_W-1:0] angle,
	output logic             v_out,
	output logic             s_neg,
	output logic [MAG_W-1:0] s_mag,
	output logic             c_neg,
	output logic [MAG_W-1:0] c_mag
);

	logic [1:0]       q_s1;
	logic [ANG_W-1:0] rem_s1;
	logic [1:0]       q_s2;
	logic             swap_s2;
	logic [18:0]      b_s2;
	logic [Q_W-1:0]   x_s3, x_s4, x2_s4;
	logic [Q_W-1:0]   sp_s5;
	logic [T_W-1:0]   ct_s5;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [1:0]       q_c;
	logic [ANG_W-1:0] rem_c;
	logic [ANG_W-1:0] rem_f;
	logic [52:0]      xprod;
	logic [2*Q_W:0]   x2prod;
	logic [Q_W+T_W-1:0] sprod;
	logic [Q_W:0]     sp_rnd;
	logic [T_W:0]     ct_rnd;
	logic [MAG_W-1:0] sv, cv, sr, cr;
	logic             sn_d, cn_d;
	logic [MAG_W-1:0] sm_d, cm_d;

	logic [T_W-1:0] cos_t [COS_N+1];
	logic           cos_v [COS_N+1];
	logic [T_W-1:0] sin_t [SIN_N+1];
	logic           sin_v [SIN_N+1];

	always_comb begin
		if (angle >= THREEQ) begin
			q_c = 2'd3; rem_c = angle - THREEQ;
		end else if (angle >= HALF) begin
			q_c = 2'd2; rem_c = angle - HALF;
		end else if (angle >= QUARTER) begin
			q_c = 2'd1; rem_c = angle - QUARTER;
		end else begin
			q_c = 2'd0; rem_c = angle;
		end
	end

	assign rem_f  = (rem_s1 > EIGHTH) ? QUARTER - rem_s1 : rem_s1;
	assign xprod  = b_s2 * RAD_Q52 + 53'(1 << 21);
	assign x2prod = x_s3 * x_s3 + (2*Q_W+1)'(1 << 29);

	assign cos_t[0] = Q30_ONE;
	assign cos_v[0] = v_s4;
	assign sin_t[0] = Q30_ONE;
	assign sin_v[0] = v_s4;

	for (genvar gi = 0; gi < COS_N; gi++) begin : g_cos
		lsc_horner_cell u_cell (
			.clk(clk), .arst_n(arst_n), .v_in(cos_v[gi]), .x2(x2_s4), .t_in(cos_t[gi]),
			.divisor(COS_DIV[gi]), .rcp(COS_RCP[gi]), .v_out(cos_v[gi+1]), .t_out(cos_t[gi+1])
		);
	end

	for (genvar gi = 0; gi < SIN_N; gi++) begin : g_sin
		lsc_horner_cell u_cell (
			.clk(clk), .arst_n(arst_n), .v_in(sin_v[gi]), .x2(x2_s4), .t_in(sin_t[gi]),
			.divisor(SIN_DIV[gi]), .rcp(SIN_RCP[gi]), .v_out(sin_v[gi+1]), .t_out(sin_t[gi+1])
		);
	end

	// sine chain is shorter and holds its result until the cosine chain ends
	assign sprod  = x_s4 * sin_t[SIN_N];
	assign sp_rnd = {1'b0, sp_s5} + (Q_W+1)'(1 << (29 - TRIG_FRAC));
	assign ct_rnd = {1'b0, ct_s5} + (T_W+1)'(1 << (29 - TRIG_FRAC));
	assign sv     = sp_rnd[30-TRIG_FRAC +: MAG_W];
	assign cv     = ct_rnd[30-TRIG_FRAC +: MAG_W];
	assign sr     = swap_s2 ? cv : sv;
	assign cr     = swap_s2 ? sv : cv;

	always_comb begin
		unique case (q_s2)
			2'd0: begin sn_d = 1'b0; sm_d = sr; cn_d = 1'b0; cm_d = cr; end
			2'd1: begin sn_d = 1'b0; sm_d = cr; cn_d = 1'b1; cm_d = sr; end
			2'd2: begin sn_d = 1'b1; sm_d = sr; cn_d = 1'b1; cm_d = cr; end
			default: begin sn_d = 1'b1; sm_d = cr; cn_d = 1'b0; cm_d = sr; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= cos_v[COS_N];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (v_in) begin
			q_s1   <= q_c;
			rem_s1 <= rem_c;
		end
		if (v_s1) begin
			q_s2    <= q_s1;
			swap_s2 <= rem_s1 > EIGHTH;
			b_s2    <= rem_f[18:0];
		end
		if (v_s2) x_s3 <= xprod[22 +: Q_W];
		if (v_s3) begin
			x_s4  <= x_s3;
			x2_s4 <= x2prod[Q_W +: Q_W];
		end
		if (cos_v[COS_N]) begin
			sp_s5 <= sprod[Q_W +: Q_W];
			ct_s5 <= cos_t[COS_N];
		end
		if (v_s5) begin
			s_neg <= sn_d;
			s_mag <= sm_d;
			c_neg <= cn_d;
			c_mag <= cm_d;
		end
	end

	assign v_out = v_s6;

endmodule

@@ rtl/core/lsc_parser.sv @@
// Telegram tokenizer and hex field parser; launches one request per distance token.
`timescale 1ns / 1ps
module lsc_parser
	import lsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_v,
	input  logic [7:0]       byte_in,
	input  logic [TBA_W-1:0] tba,
	input  logic [ANG_W-1:0] first_angle,
	input  logic [ANG_W-1:0] angle_step,
	output launch_t          launch
);

	phase_t           phase_q, phase_d;
	logic [TBA_W-1:0] tok_q, tok_d;
	logic             in_tok_q, in_tok_d;
	logic [HEX_W-1:0] hex_q, hex_d;
	logic             stop_q, stop_d;
	logic [CNT_W-1:0] exp_q, exp_d;
	logic [CNT_W-1:0] pc_q, pc_d;
	logic [ANG_W-1:0] ang_q, ang_d;
	logic             fire;
	logic             is_digit;
	logic [3:0]       digit;
	logic [ANG_W-1:0] step_mod;
	logic [ANG_W:0]   ang_sum;
	logic [ANG_W-1:0] ang_next;
	logic [ANG_W:0]   first_wrap;
	logic [ANG_W-1:0] first_norm;
	logic [CNT_W-1:0] pc_inc;

	assign step_mod   = (angle_step >= TURN) ? angle_step - TURN : angle_step;
	assign ang_sum    = {1'b0, ang_q} + {1'b0, step_mod};
	assign ang_next   = (ang_sum >= {1'b0, TURN}) ? ANG_W'(ang_sum - {1'b0, TURN})
		: ang_sum[ANG_W-1:0];
	assign first_wrap = {first_angle[ANG_W-1], first_angle} + {1'b0, TURN};
	assign first_norm = first_angle[ANG_W-1] ? first_wrap[ANG_W-1:0] : first_angle;
	assign pc_inc     = pc_q + 1'b1;

	always_comb begin
		is_digit = 1'b1;
		digit    = 4'd0;
		if (byte_in >= "0" && byte_in <= "9") digit = 4'(byte_in - "0");
		else if (byte_in >= "A" && byte_in <= "F") digit = 4'(byte_in - "A" + 8'd10);
		else if (byte_in >= "a" && byte_in <= "f") digit = 4'(byte_in - "a" + 8'd10);
		else is_digit = 1'b0;
	end

	always_comb begin
		phase_d  = phase_q;
		tok_d    = tok_q;
		in_tok_d = in_tok_q;
		hex_d    = hex_q;
		stop_d   = stop_q;
		exp_d    = exp_q;
		pc_d     = pc_q;
		ang_d    = ang_q;
		fire     = 1'b0;
		if (byte_v) begin
			if (byte_in == CH_STX) begin
				phase_d  = PH_HEAD;
				tok_d    = '0;
				in_tok_d = 1'b0;
				hex_d    = '0;
				stop_d   = 1'b0;
			end else if (phase_q == PH_IDLE) begin
				phase_d = PH_IDLE;
			end else if (byte_in == CH_SP || byte_in == CH_ETX) begin
				if (in_tok_q) begin
					unique case (phase_q)
						PH_HEAD: begin
							if (tok_q == tba) phase_d = PH_STEP;
							else tok_d = tok_q + 1'b1;
						end
						PH_STEP: phase_d = PH_COUNT;
						PH_COUNT: begin
							exp_d   = (hex_q > HEX_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
								: hex_q[CNT_W-1:0];
							phase_d = PH_GAP;
						end
						PH_GAP: begin
							pc_d    = '0;
							ang_d   = first_norm;
							phase_d = (exp_q == '0) ? PH_DONE : PH_DIST;
						end
						PH_DIST: begin
							fire  = 1'b1;
							pc_d  = pc_inc;
							ang_d = ang_next;
							if (pc_inc >= exp_q) phase_d = PH_DONE;
						end
						default: phase_d = phase_q;
					endcase
				end
				in_tok_d = 1'b0;
				hex_d    = '0;
				stop_d   = 1'b0;
				if (byte_in == CH_ETX) phase_d = PH_IDLE;
			end else begin
				in_tok_d = 1'b1;
				if (phase_q != PH_DONE && !stop_q) begin
					if (!is_digit) stop_d = 1'b1;
					else if (hex_q > 32'h0FFF_FFFF) hex_d = '1;
					else hex_d = {hex_q[HEX_W-5:0], digit};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tok_q    <= '0;
			in_tok_q <= 1'b0;
			hex_q    <= '0;
			stop_q   <= 1'b0;
			exp_q    <= '0;
			pc_q     <= '0;
			ang_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			tok_q    <= tok_d;
			in_tok_q <= in_tok_d;
			hex_q    <= hex_d;
			stop_q   <= stop_d;
			exp_q    <= exp_d;
			pc_q     <= pc_d;
			ang_q    <= ang_d;
		end
	end

	assign launch.valid = fire;
	assign launch.r     = hex_q;
	assign launch.angle = ang_q;
	assign launch.pnum  = PNUM_W'(pc_q);
	assign launch.last  = (pc_inc == exp_q);

endmodule

@@ rtl/core/lidar_scan_to_cartesian_top.sv @@
// Top level: config registers, parser, trig chain, projection and output register.
`timescale 1ns / 1ps
// Usage:
// Telegram bytes enter on in_valid/in_ready/telegram_byte. A request is taken
// on a clock edge with in_valid and in_ready high. Most bytes are taken one per
// cycle. A space or ETX that closes a distance token starts one point; in_ready
// then stays low until that point has been taken on the output side.
// The point appears on out_valid with point_number, x_mm, y_mm, final_point
// after the closing byte passes through octant fold and radian scaling,
// six three-stage Horner cells for the cosine series (the sine series runs
// alongside in five cells), rounding and quadrant selection, and projection.
// A stalled receiver holds the result in the output register and keeps
// in_ready low.
// Configuration writes (cfg_valid/cfg_index/cfg_data) are always taken;
// index 0 token count, 1 first angle, 2 angle step; other indexes are ignored.
// Reset puts the parser idle until the next STX and loads the default
// register values.
module lidar_scan_to_cartesian_top
	import lsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         telegram_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PNUM_W-1:0]  point_number,
	output logic [COORD_W-1:0] x_mm,
	output logic [COORD_W-1:0] y_mm,
	output logic               final_point,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [ANG_W-1:0]   cfg_data
);

	logic [TBA_W-1:0]  tba_q;
	logic [ANG_W-1:0]  first_q;
	logic [ANG_W-1:0]  step_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [HEX_W-1:0]  r_q;
	logic [PNUM_W-1:0] pnum_q;
	logic              last_q;
	logic              in_acc;
	launch_t           launch;
	logic              t_v, s_neg, c_neg;
	logic [MAG_W-1:0]  s_mag, c_mag;
	logic              v_s1;
	logic [PX_W-1:0]   px_s1, py_s1;
	logic              xn_s1, yn_s1;
	logic [COORD_W-1:0] x_q, y_q;

	assign in_ready  = !busy_q;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	lsc_parser u_parser (
		.clk(clk), .arst_n(arst_n), .byte_v(in_acc), .byte_in(telegram_byte),
		.tba(tba_q), .first_angle(first_q), .angle_step(step_q), .launch(launch)
	);

	lsc_trig u_trig (
		.clk(clk), .arst_n(arst_n), .v_in(launch.valid), .angle(launch.angle),
		.v_out(t_v), .s_neg(s_neg), .s_mag(s_mag), .c_neg(c_neg), .c_mag(c_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tba_q   <= TBA_W'(23);
			first_q <= ANG_W'(-450000);
			step_q  <= ANG_W'(5000);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TBA:   tba_q   <= cfg_data[TBA_W-1:0];
				CFG_FIRST: first_q <= cfg_data;
				CFG_STEP:  step_q  <= cfg_data;
				default:   tba_q   <= tba_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= t_v;
			if (launch.valid) busy_q <= 1'b1;
			else if (out_valid_q && out_ready) busy_q <= 1'b0;
			if (v_s1) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (launch.valid) begin
			r_q    <= launch.r;
			pnum_q <= launch.pnum;
			last_q <= launch.last;
		end
		if (t_v) begin
			px_s1 <= r_q * s_mag;
			py_s1 <= r_q * c_mag;
			xn_s1 <= s_neg;
			yn_s1 <= c_neg;
		end
		if (v_s1) begin
			x_q <= project(px_s1, xn_s1);
			y_q <= project(py_s1, yn_s1);
		end
	end

	assign out_valid    = out_valid_q;
	assign point_number = pnum_q;
	assign x_mm         = x_q;
	assign y_mm         = y_q;
	assign final_point  = last_q;

endmodule

@@ rtl/core/lsc_checker.sv @@
// Port-level assertions for the lidar scan to cartesian top level, with bind.
`timescale 1ns / 1ps
module lsc_checker
	import lsc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [7:0]         telegram_byte,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PNUM_W-1:0]  point_number,
	input logic [COORD_W-1:0] x_mm,
	input logic [COORD_W-1:0] y_mm,
	input logic               final_point,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	a_no_input_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result waits");

	a_stx_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && telegram_byte == CH_STX) |=> !out_valid)
		else $error("result right after start byte");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(x_mm) && $stable(y_mm)
			&& $stable(point_number) && $stable(final_point)))
		else $error("stalled result changed");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_mm != 17'h10000 && y_mm != 17'h10000))
		else $error("coordinate outside saturation range");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write not taken");

endmodule

bind lidar_scan_to_cartesian_top lsc_checker u_lsc_checker (.*);
